[rtl/core/sawarq_pkg.sv]
`timescale 1ns / 1ps

package sawarq_pkg;

   // default chunk store depth and widest length field it may need
   localparam int CHUNK_BYTES_DEF = 10;
   localparam int LEN_MAX_W       = 7;

   localparam logic [2:0] RETRY_LIMIT_RST = 3'd3;

   // request codes on the input channel
   typedef enum logic [1:0] {
      REQ_DATA    = 2'd0,
      REQ_ACK     = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   // result codes on the output channel
   typedef enum logic [1:0] {
      OUT_PKT  = 2'd0,
      OUT_NEXT = 2'd1,
      OUT_FIN  = 2'd2
   } out_kind_type;

   // sender protocol phase
   typedef enum logic [1:0] {
      PH_LOADING = 2'd0,
      PH_WAITING = 2'd1,
      PH_FINAL   = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   // job handed from the protocol controller to the run sequencer
   typedef struct packed {
      out_kind_type           kind;
      logic                   seq;
      logic [LEN_MAX_W-1:0]   len;
      logic [7:0]             ck;
   } cmd_type;

endpackage

[rtl/core/sawarq_store.sv]
`timescale 1ns / 1ps

module sawarq_store import sawarq_pkg::*; #(
   parameter int DEPTH = CHUNK_BYTES_DEF,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sawarq_ctrl.sv]
`timescale 1ns / 1ps

module sawarq_ctrl import sawarq_pkg::*; #(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
   parameter int LEN_W       = 4,
   parameter int IDX_W       = 4
) (
   input  logic             clock,
   input  logic             reset,
   // request beats
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [7:0]       req_data_byte,
   input  logic             req_chunk_end,
   input  logic             req_chunk_empty,
   input  logic             req_ack_seq,
   input  logic [LEN_W-1:0] req_ack_len,
   input  logic [7:0]       req_ack_cksum,
   input  logic [7:0]       req_ack_payload_xor,
   // retry limit register
   input  logic             csr_valid,
   input  logic [2:0]       csr_data,
   // chunk store write port
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [7:0]       wr_data,
   // job to the run sequencer
   output logic             cmd_valid,
   output cmd_type          cmd
);

   phase_type        phase_ff, phase_in;
   logic             seq_ff, seq_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       xor_ff, xor_in;
   logic [2:0]       retry_ff, retry_in;
   logic [2:0]       limit_ff;

   logic             accept;
   logic             room;
   logic [LEN_W-1:0] fill_inc;
   logic [7:0]       xor_inc;
   logic             chunk_done;
   logic [7:0]       ack_want;
   logic             ack_good;
   logic             retry_out;

   assign accept = req_valid & req_ready;

   // load path: next fill, running xor and chunk close
   assign room       = fill_ff < LEN_W'(CHUNK_BYTES);
   assign fill_inc   = room ? fill_ff + LEN_W'(1) : fill_ff;
   assign xor_inc    = room ? xor_ff ^ req_data_byte : xor_ff;
   assign chunk_done = req_chunk_end | (fill_inc >= LEN_W'(CHUNK_BYTES));

   // ack check against the checksum the receiver should have computed
   assign ack_want  = {7'd0, req_ack_seq} ^ 8'(req_ack_len) ^ req_ack_payload_xor;
   assign ack_good  = (req_ack_seq == seq_ff) && (req_ack_cksum == ack_want);
   assign retry_out = retry_ff >= limit_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_LOADING: begin
               if (req_type == REQ_DATA) begin
                  if (req_chunk_empty) begin
                     phase_in = PH_FINAL;
                  end else if (chunk_done) begin
                     phase_in = PH_WAITING;
                  end
               end
            end
            PH_WAITING: begin
               if (req_type == REQ_ACK && ack_good) begin
                  phase_in = PH_LOADING;
               end
            end
            PH_FINAL: begin
               if (req_type == REQ_ACK) begin
                  phase_in = PH_DONE;
               end else if (req_type == REQ_TIMEOUT && retry_out) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // datapath and job issue
   always_comb begin
      seq_in    = seq_ff;
      fill_in   = fill_ff;
      xor_in    = xor_ff;
      retry_in  = retry_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[IDX_W-1:0];
      wr_data   = req_data_byte;
      cmd_valid = 1'b0;
      cmd.kind  = OUT_PKT;
      cmd.seq   = seq_ff;
      cmd.len   = LEN_MAX_W'(fill_ff);
      cmd.ck    = {7'd0, seq_ff} ^ 8'(fill_ff) ^ xor_ff;
      if (accept) begin
         case (phase_ff)
            PH_LOADING: begin
               if (req_type == REQ_DATA) begin
                  if (req_chunk_empty) begin
                     // drop any partial chunk, send the empty final packet
                     fill_in   = '0;
                     xor_in    = '0;
                     retry_in  = '0;
                     cmd_valid = 1'b1;
                     cmd.len   = '0;
                     cmd.ck    = {7'd0, seq_ff};
                  end else begin
                     wr_en  = room;
                     fill_in = fill_inc;
                     xor_in  = xor_inc;
                     if (chunk_done) begin
                        cmd_valid = 1'b1;
                        cmd.len   = LEN_MAX_W'(fill_inc);
                        cmd.ck    = {7'd0, seq_ff} ^ 8'(fill_inc) ^ xor_inc;
                     end
                  end
               end
            end
            PH_WAITING: begin
               if (req_type == REQ_ACK && ack_good) begin
                  seq_in    = ~seq_ff;
                  fill_in   = '0;
                  xor_in    = '0;
                  cmd_valid = 1'b1;
                  cmd.kind  = OUT_NEXT;
                  cmd.seq   = ~seq_ff;
                  cmd.len   = '0;
                  cmd.ck    = '0;
               end else if (req_type == REQ_ACK || req_type == REQ_TIMEOUT) begin
                  cmd_valid = 1'b1;
               end
            end
            PH_FINAL: begin
               if (req_type == REQ_ACK || (req_type == REQ_TIMEOUT && retry_out)) begin
                  cmd_valid = 1'b1;
                  cmd.kind  = OUT_FIN;
                  cmd.seq   = 1'b0;
                  cmd.len   = '0;
                  cmd.ck    = '0;
               end else if (req_type == REQ_TIMEOUT) begin
                  retry_in  = retry_ff + 3'd1;
                  cmd_valid = 1'b1;
               end
            end
            default: begin
               cmd_valid = 1'b0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LOADING;
         seq_ff   <= 1'b0;
         fill_ff  <= '0;
         xor_ff   <= '0;
         retry_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         retry_ff <= retry_in;
      end
   end

   // retry limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_LIMIT_RST;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

endmodule

[rtl/core/sawarq_run.sv]
`timescale 1ns / 1ps

module sawarq_run import sawarq_pkg::*; #(
   parameter int LEN_W = 4,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   // job from the controller
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             idle,
   // chunk store read port
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr,
   input  logic [7:0]       rd_data,
   // result beats
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic             rsp_pkt_seq,
   output logic [LEN_W-1:0] rsp_pkt_len,
   output logic [7:0]       rsp_pkt_cksum,
   output logic [7:0]       rsp_pkt_byte,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic             rsp_last_item
);

   // job registers
   logic             busy_ff, busy_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   out_kind_type     kind_ff;
   logic             seq_ff;
   logic [LEN_W-1:0] len_ff;
   logic [7:0]       ck_ff;

   // output register
   logic             out_valid_ff, out_valid_in;
   out_kind_type     out_kind_ff;
   logic             out_seq_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic [7:0]       out_ck_ff;
   logic [7:0]       out_byte_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff;

   logic need_rd;
   logic out_free;
   logic last_rd;
   logic load;

   assign need_rd  = (kind_ff == OUT_PKT) && (len_ff != '0);
   assign out_free = ~out_valid_ff | rsp_ready;
   assign last_rd  = ((LEN_W + 1)'(idx_ff) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(len_ff);
   assign load     = busy_ff && out_free && (~need_rd || pend_ff);

   // store read: prime first byte, then fetch the next one as each beat loads
   assign rd_en   = busy_ff && need_rd && (~pend_ff || (out_free && ~last_rd));
   assign rd_addr = pend_ff ? idx_ff + IDX_W'(1) : idx_ff;

   // sequencer next state
   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      idx_in  = idx_ff;
      if (cmd_valid) begin
         busy_in = 1'b1;
         pend_in = 1'b0;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (need_rd && ~pend_ff) begin
            pend_in = 1'b1;
         end else if (load) begin
            if (~need_rd || last_rd) begin
               busy_in = 1'b0;
               pend_in = 1'b0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // job header capture
   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         kind_ff <= cmd.kind;
         seq_ff  <= cmd.seq;
         len_ff  <= cmd.len[LEN_W-1:0];
         ck_ff   <= cmd.ck;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff <= kind_ff;
         out_seq_ff  <= seq_ff;
         out_len_ff  <= len_ff;
         out_ck_ff   <= ck_ff;
         out_byte_ff <= need_rd ? rd_data : 8'd0;
         out_idx_ff  <= need_rd ? idx_ff : '0;
         out_last_ff <= need_rd ? last_rd : (kind_ff == OUT_PKT);
      end
   end

   assign idle           = ~busy_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_out_kind   = out_kind_ff;
   assign rsp_pkt_seq    = out_seq_ff;
   assign rsp_pkt_len    = out_len_ff;
   assign rsp_pkt_cksum  = out_ck_ff;
   assign rsp_pkt_byte   = out_byte_ff;
   assign rsp_byte_index = out_idx_ff;
   assign rsp_last_item  = out_last_ff;

endmodule

[rtl/core/stop_and_wait_arq_sender.sv]
`timescale 1ns / 1ps
// Alternating-bit sender.
// req channel: one beat per request. req_type selects a chunk data byte, a
// received ack (seq, len, checksum, payload xor) or a timeout tick. Data
// bytes are stored one per cycle while ready; a byte flagged chunk_end, or the
// one that fills the store, closes the chunk and starts a packet run.
// rsp channel: a packet run is one beat per payload byte (one beat for an
// empty packet) carrying seq, length and checksum, last_item on the final
// beat. A good ack gives one request-next beat, the end of the transfer one
// finished beat.
// csr channel: final_retry_limit, always ready; write only while idle.
// A request that causes results passes the job registers, then the output
// register; a packet with payload has a store read between the two, and its
// bytes come through the single read port of the chunk store one at a time.
// Requests that cause no result leave req_ready high. Reset clears the
// sequence bit, fill count, retry counter and output valid and loads a retry
// limit of 3. When rsp_ready is low the run holds in place; req_ready stays
// low until the last beat of the run is loaded into the output register.
module stop_and_wait_arq_sender import sawarq_pkg::*; #(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
   localparam int LEN_W = $clog2(CHUNK_BYTES + 1),
   localparam int IDX_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_data_byte,
   input  logic               req_chunk_end,
   input  logic               req_chunk_empty,
   input  logic               req_ack_seq,
   input  logic [LEN_W-1:0]   req_ack_len,
   input  logic signed [7:0]  req_ack_cksum,
   input  logic [7:0]         req_ack_payload_xor,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_out_kind,
   output logic               rsp_pkt_seq,
   output logic [LEN_W-1:0]   rsp_pkt_len,
   output logic signed [7:0]  rsp_pkt_cksum,
   output logic [7:0]         rsp_pkt_byte,
   output logic [IDX_W-1:0]   rsp_byte_index,
   output logic               rsp_last_item,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_data
);

   logic             run_idle;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [7:0]       ck_bits;

   // new requests only while no run is being sequenced
   assign req_ready = run_idle;
   assign csr_ready = 1'b1;

   sawarq_ctrl #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_data_byte       (req_data_byte),
      .req_chunk_end       (req_chunk_end),
      .req_chunk_empty     (req_chunk_empty),
      .req_ack_seq         (req_ack_seq),
      .req_ack_len         (req_ack_len),
      .req_ack_cksum       ($unsigned(req_ack_cksum)),
      .req_ack_payload_xor (req_ack_payload_xor),
      .csr_valid           (csr_valid),
      .csr_data            (csr_data),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd)
   );

   sawarq_store #(
      .DEPTH (CHUNK_BYTES),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sawarq_run #(
      .LEN_W (LEN_W),
      .IDX_W (IDX_W)
   ) u_run (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .idle           (run_idle),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_pkt_seq    (rsp_pkt_seq),
      .rsp_pkt_len    (rsp_pkt_len),
      .rsp_pkt_cksum  (ck_bits),
      .rsp_pkt_byte   (rsp_pkt_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last_item  (rsp_last_item)
   );

   assign rsp_pkt_cksum = $signed(ck_bits);

   // a job is only issued to an idle sequencer
   assert property (@(posedge clock) disable iff (reset) cmd_valid |-> run_idle)
      else $error("job issued while run busy");

   // the store is never written while a run reads it
   assert property (@(posedge clock) disable iff (reset) wr_en |-> run_idle)
      else $error("store write during run");

   // the last beat of a payload packet sits at the end of the packet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == OUT_PKT && rsp_last_item && rsp_pkt_len != '0) |->
      ((LEN_W + 1)'(rsp_byte_index) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(rsp_pkt_len))
      else $error("last beat index does not match length");

   // a taken packet beat that is not the last is followed by no beat or by the beat of the next byte index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_out_kind == OUT_PKT && !rsp_last_item) |=>
      (rsp_out_kind == OUT_PKT && rsp_byte_index == $past(rsp_byte_index) + IDX_W'(1)) ||
      !rsp_valid)
      else $error("packet run beat out of order");

endmodule
